[rtl/core/mtep_pkg.sv]
// types and constants shared by the midi track event parser and its checker
package mtep_pkg;

  localparam int unsigned QTY_BITS = 28;
  localparam int unsigned OUT_TICK_BITS = 32;
  localparam int unsigned QTY_MAX_BYTES = 3;

  localparam logic [7:0] BYTE_META = 8'hFF;
  localparam logic [7:0] BYTE_SYSEX = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_ESC = 8'hF7;
  localparam logic [3:0] HI_PROG = 4'hC;
  localparam logic [3:0] HI_PRESS = 4'hD;

  localparam logic [2:0] FAULT_NONE = 3'd0;
  localparam logic [2:0] FAULT_BAD_STATUS = 3'd1;
  localparam logic [2:0] FAULT_NO_RUNNING = 3'd2;
  localparam logic [2:0] FAULT_LONG_LEN = 3'd3;
  localparam logic [2:0] FAULT_TRUNCATED = 3'd4;

  typedef struct packed {
    logic [2:0]  fault;
    logic        last;
    logic        first;
    logic [31:0] tick;
    logic [7:0]  data;
  } result_t;

endpackage

[rtl/core/midi_track_event_parser.sv]
// midi track event parser: delta time decode, event byte tagging, fault flagging
// results are written into the result queue when the input transfer that causes them is taken
// throughput: one input byte per cycle while the result queue has room; a running-status
// data byte gives two result transfers, so the single result port then sets the pace
// results wait in a four-entry result queue; input is taken while at least two slots are free
// reset (rst_n low, synchronous) clears parse state, tick, running status, halt and queue
module midi_track_event_parser #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // track_start
  input  logic        in_tlast,   // track_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // event_byte [7:0], event_tick [39:8]
  output logic [3:0]  out_tuser,  // event_first [0], fault [3:1]
  output logic        out_tlast   // event_last
);

  localparam int unsigned TW = (TICK_BITS < 32) ? TICK_BITS : 32;
  localparam logic [32:0] TICK_CAP = (33'd1 << TW) - 33'd1;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_MTYPE,
    PH_LEN,
    PH_DATA
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [TW-1:0]                   tick_r, tick_nxt;
  logic [mtep_pkg::QTY_BITS-1:0]   acc_r, acc_nxt;
  logic [2:0]                      qbytes_r, qbytes_nxt;
  logic [mtep_pkg::QTY_BITS-1:0]   left_r, left_nxt;
  logic [7:0]                      rstat_r, rstat_nxt;
  logic                            halted_r, halted_nxt;

  mtep_pkg::result_t               queue_r [QDEPTH];
  logic [QPW-1:0]                  wr_ptr_r, rd_ptr_r;
  logic [QPW:0]                    count_r;

  phase_t                          ph_c;
  logic [TW-1:0]                   tick_c;
  logic [mtep_pkg::QTY_BITS-1:0]   acc_c, left_c, acc_take, left_dec;
  logic [2:0]                      qbytes_c;
  logic [7:0]                      rstat_c, b;
  logic                            halted_c, too_long, qty_done, done, one_byte, rs_one;
  logic [32:0]                     tick_sum;
  logic [2:0]                      fault;
  logic [1:0]                      n_res;
  mtep_pkg::result_t               res0, res1;
  logic                            in_xfer, out_xfer;
  logic [1:0]                      n_push;

  assign in_xfer = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign in_tready = (count_r <= (QPW + 1)'(QDEPTH - 2));
  assign b = in_tdata;

  always_comb begin
    ph_c = in_tuser ? PH_DELTA : phase_r;
    tick_c = in_tuser ? '0 : tick_r;
    acc_c = in_tuser ? '0 : acc_r;
    qbytes_c = in_tuser ? '0 : qbytes_r;
    left_c = in_tuser ? '0 : left_r;
    rstat_c = in_tuser ? '0 : rstat_r;
    halted_c = in_tuser ? 1'b0 : halted_r;

    too_long = b[7] && (qbytes_c >= 3'(mtep_pkg::QTY_MAX_BYTES));
    acc_take = {acc_c[mtep_pkg::QTY_BITS-8:0], b[6:0]};
    qty_done = !b[7];
    tick_sum = 33'(tick_c) + 33'(acc_take);
    left_dec = (left_c != '0) ? left_c - 1'b1 : '0;
    one_byte = (b[7:4] == mtep_pkg::HI_PROG) || (b[7:4] == mtep_pkg::HI_PRESS);
    rs_one = (rstat_c[7:4] == mtep_pkg::HI_PROG) || (rstat_c[7:4] == mtep_pkg::HI_PRESS);

    phase_nxt = ph_c;
    tick_nxt = tick_c;
    acc_nxt = acc_c;
    qbytes_nxt = qbytes_c;
    left_nxt = left_c;
    rstat_nxt = rstat_c;
    halted_nxt = halted_c;
    fault = mtep_pkg::FAULT_NONE;
    done = 1'b0;
    n_res = 2'd0;
    res0 = '{fault: mtep_pkg::FAULT_NONE, last: 1'b0, first: 1'b0, tick: '0, data: b};
    res1 = res0;

    if (!halted_c) begin
      unique case (ph_c)
        PH_STATUS: begin
          if (b == mtep_pkg::BYTE_META) begin
            rstat_nxt = '0;
            res0.first = 1'b1;
            n_res = 2'd1;
            phase_nxt = PH_MTYPE;
          end else if (b == mtep_pkg::BYTE_SYSEX || b == mtep_pkg::BYTE_SYSEX_ESC) begin
            rstat_nxt = '0;
            res0.first = 1'b1;
            n_res = 2'd1;
            acc_nxt = '0;
            qbytes_nxt = '0;
            phase_nxt = PH_LEN;
          end else if (b[7]) begin
            if (b > mtep_pkg::BYTE_SYSEX) begin
              fault = mtep_pkg::FAULT_BAD_STATUS;
            end else begin
              rstat_nxt = b;
              res0.first = 1'b1;
              n_res = 2'd1;
              left_nxt = one_byte ? mtep_pkg::QTY_BITS'(1) : mtep_pkg::QTY_BITS'(2);
              phase_nxt = PH_DATA;
            end
          end else if (rstat_c[7]) begin
            res0.data = rstat_c;
            res0.first = 1'b1;
            res1.last = rs_one;
            n_res = 2'd2;
            if (rs_one) begin
              done = 1'b1;
              phase_nxt = PH_DELTA;
              acc_nxt = '0;
              qbytes_nxt = '0;
            end else begin
              left_nxt = mtep_pkg::QTY_BITS'(1);
              phase_nxt = PH_DATA;
            end
          end else begin
            fault = mtep_pkg::FAULT_NO_RUNNING;
          end
        end
        PH_MTYPE: begin
          n_res = 2'd1;
          acc_nxt = '0;
          qbytes_nxt = '0;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (too_long) begin
            fault = mtep_pkg::FAULT_LONG_LEN;
          end else begin
            acc_nxt = acc_take;
            qbytes_nxt = qbytes_c + 3'd1;
            n_res = 2'd1;
            if (qty_done) begin
              left_nxt = acc_take;
              if (acc_take == '0) begin
                res0.last = 1'b1;
                done = 1'b1;
                phase_nxt = PH_DELTA;
                acc_nxt = '0;
                qbytes_nxt = '0;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          left_nxt = left_dec;
          n_res = 2'd1;
          if (left_dec == '0) begin
            res0.last = 1'b1;
            done = 1'b1;
            phase_nxt = PH_DELTA;
            acc_nxt = '0;
            qbytes_nxt = '0;
          end
        end
        default: begin
          if (too_long) begin
            fault = mtep_pkg::FAULT_LONG_LEN;
          end else if (qty_done) begin
            tick_nxt = (tick_sum > TICK_CAP) ? TICK_CAP[TW-1:0] : tick_sum[TW-1:0];
            acc_nxt = '0;
            qbytes_nxt = '0;
            phase_nxt = PH_STATUS;
          end else begin
            acc_nxt = acc_take;
            qbytes_nxt = qbytes_c + 3'd1;
          end
        end
      endcase

      if (fault != mtep_pkg::FAULT_NONE) begin
        phase_nxt = ph_c;
        tick_nxt = tick_c;
        acc_nxt = acc_c;
        qbytes_nxt = qbytes_c;
        left_nxt = left_c;
        rstat_nxt = rstat_c;
        halted_nxt = 1'b1;
        res0 = '{fault: fault, last: 1'b0, first: 1'b0, tick: '0, data: b};
        n_res = 2'd1;
      end else if (in_tlast && !done) begin
        halted_nxt = 1'b1;
        priority case (n_res)
          2'd2: res1.fault = mtep_pkg::FAULT_TRUNCATED;
          2'd1: res0.fault = mtep_pkg::FAULT_TRUNCATED;
          default: begin
            res0 = '{fault: mtep_pkg::FAULT_TRUNCATED, last: 1'b0, first: 1'b0,
                     tick: '0, data: b};
            n_res = 2'd1;
          end
        endcase
      end
    end

    res0.tick = 32'(tick_nxt);
    res1.tick = 32'(tick_nxt);
  end

  assign n_push = in_xfer ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      tick_r <= '0;
      acc_r <= '0;
      qbytes_r <= '0;
      left_r <= '0;
      rstat_r <= '0;
      halted_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (in_xfer) begin
        phase_r <= phase_nxt;
        tick_r <= tick_nxt;
        acc_r <= acc_nxt;
        qbytes_r <= qbytes_nxt;
        left_r <= left_nxt;
        rstat_r <= rstat_nxt;
        halted_r <= halted_nxt;
      end
      wr_ptr_r <= wr_ptr_r + QPW'(n_push);
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QPW + 1)'(n_push) - (QPW + 1)'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_r + 1'b1] <= res1;
    end
  end

  assign out_tvalid = (count_r != '0);
  assign out_tdata = {queue_r[rd_ptr_r].tick, queue_r[rd_ptr_r].data};
  assign out_tuser = {queue_r[rd_ptr_r].fault, queue_r[rd_ptr_r].first};
  assign out_tlast = queue_r[rd_ptr_r].last;

endmodule

[rtl/core/mtep_checker.sv]
// port-level checker for the midi track event parser, with its bind
module mtep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // an event opens on a status byte
  a_first_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[7])
    else $error("first byte of event is not a status byte");

  // parse faults carry no event marks
  a_fault_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3:1] == mtep_pkg::FAULT_BAD_STATUS
      || out_tuser[3:1] == mtep_pkg::FAULT_NO_RUNNING
      || out_tuser[3:1] == mtep_pkg::FAULT_LONG_LEN) |-> !out_tuser[0] && !out_tlast)
    else $error("fault transfer carries first or last mark");

  // no undefined fault code
  a_fault_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[3:1] <= mtep_pkg::FAULT_TRUNCATED)
    else $error("undefined fault code");

  // result queue empty straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid && in_tready)
    else $error("results present after reset");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);
